// ===== rtl/hash_cache_with_group_fifo_eviction_assert.svh =====
// Assertion macros used by the hash cache controller (hcgfe_ctrl).
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef HASH_CACHE_WITH_GROUP_FIFO_EVICTION_ASSERT_SVH
`define HASH_CACHE_WITH_GROUP_FIFO_EVICTION_ASSERT_SVH

// Same-cycle implication.
`define HCGFE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HCGFE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hcgfe_pkg.sv =====
// ----------------------------------------------------------------------------
// hcgfe_pkg
// Types and constants of the hash cache with group FIFO eviction.
// ----------------------------------------------------------------------------
`default_nettype none

package hcgfe_pkg;

    localparam int KEY_W  = 256;
    localparam int BLK_W  = 64;
    localparam int ITEM_W = 32;
    localparam int CNT_W  = 14;

    localparam logic [1:0] CMD_INSERT  = 2'd0;
    localparam logic [1:0] CMD_LOOKUP  = 2'd1;
    localparam logic [1:0] CMD_RESERVE = 2'd2;
    localparam logic [1:0] CMD_CLEAR   = 2'd3;

    localparam logic [CNT_W-1:0] MAX_ENTRIES_RESET = 14'd10000;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [63:0]       key_word0;
        logic [63:0]       key_word1;
        logic [63:0]       key_word2;
        logic [63:0]       key_word3;
        logic [BLK_W-1:0]  block_value;
        logic [ITEM_W-1:0] item_value;
        logic [CNT_W-1:0]  room_count;
    } hcgfe_req_t;

    typedef struct packed {
        logic              found;
        logic [BLK_W-1:0]  found_block;
        logic [ITEM_W-1:0] found_item;
        logic [CNT_W-1:0]  entries_held;
    } hcgfe_rsp_t;

    // one hash table slot
    typedef struct packed {
        logic              used;
        logic [KEY_W-1:0]  key;
        logic [BLK_W-1:0]  blk;
        logic [ITEM_W-1:0] item;
    } hcgfe_slot_t;

    // one insertion-order queue entry
    typedef struct packed {
        logic             group_start;
        logic [KEY_W-1:0] key;
    } hcgfe_order_t;

endpackage

`default_nettype wire

// ===== rtl/hcgfe_ram.sv =====
// ----------------------------------------------------------------------------
// hcgfe_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hcgfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/hcgfe_ctrl.sv =====
// ----------------------------------------------------------------------------
// hcgfe_ctrl
// Command sequencer: probes, backward-shift deletes, group eviction and the
// clearing sweep, over the slot table RAM and the order queue RAM.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hash_cache_with_group_fifo_eviction_assert.svh"

module hcgfe_ctrl
    import hcgfe_pkg::*;
#(
    parameter int SLOTS = 16384
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire hcgfe_req_t               request,
    input  wire logic [$clog2(SLOTS)-1:0] limit,
    output logic                          done,
    output hcgfe_rsp_t                    result
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int SUM_W  = ((SLOT_W > CNT_W) ? SLOT_W : CNT_W) + 1;
    localparam logic [SLOT_W-1:0] IDX_LAST = SLOT_W'(SLOTS - 1);

    localparam logic [2:0] S_CLR    = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EV_CHK = 3'd2;
    localparam logic [2:0] S_EV_DAT = 3'd3;
    localparam logic [2:0] S_PROBE  = 3'd4;
    localparam logic [2:0] S_DEL    = 3'd5;

    localparam logic [1:0] MODE_LOOK  = 2'd0;
    localparam logic [1:0] MODE_INS   = 2'd1;
    localparam logic [1:0] MODE_EVICT = 2'd2;

    function automatic logic [SLOT_W-1:0] next_idx(input logic [SLOT_W-1:0] i);
        return (i == IDX_LAST) ? '0 : i + SLOT_W'(1);
    endfunction

    function automatic logic [SLOT_W-1:0] home_of(input logic [KEY_W-1:0] k);
        return k[SLOT_W-1:0];
    endfunction

    function automatic logic [KEY_W-1:0] key_of(input hcgfe_req_t r);
        return {r.key_word3, r.key_word2, r.key_word1, r.key_word0};
    endfunction

    // h lies cyclically in (lo, hi]
    function automatic logic in_range(input logic [SLOT_W-1:0] lo,
                                      input logic [SLOT_W-1:0] h,
                                      input logic [SLOT_W-1:0] hi);
        if (lo <= hi)
        begin
            return (h > lo) && (h <= hi);
        end
        return (h > lo) || (h <= hi);
    endfunction

    logic [2:0]        state_reg, state_next;
    logic [1:0]        mode_reg, mode_next;
    hcgfe_req_t        req_reg, req_next;
    logic [CNT_W-1:0]  need_reg, need_next;
    logic              first_reg, first_next;
    logic [KEY_W-1:0]  pkey_reg, pkey_next;
    logic [SLOT_W-1:0] pidx_reg, pidx_next;
    logic [SLOT_W-1:0] hole_reg, hole_next;
    logic [SLOT_W-1:0] scan_reg, scan_next;
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [SLOT_W-1:0] tail_reg, tail_next;
    logic [SLOT_W-1:0] count_reg, count_next;
    logic [BLK_W-1:0]  newest_blk_reg, newest_blk_next;
    logic              newest_vld_reg, newest_vld_next;
    logic [SLOT_W-1:0] clr_addr_reg, clr_addr_next;
    logic              clr_reply_reg, clr_reply_next;
    logic              done_reg, done_next;
    hcgfe_rsp_t        result_reg, result_next;

    logic              slot_we;
    logic [SLOT_W-1:0] slot_waddr;
    hcgfe_slot_t       slot_wdata;
    logic [SLOT_W-1:0] slot_raddr;
    hcgfe_slot_t       slot_rd;
    logic              order_we;
    hcgfe_order_t      order_wdata;
    logic [SLOT_W-1:0] order_raddr;
    hcgfe_order_t      order_rd;

    logic              hit;
    logic [SUM_W-1:0]  demand;
    logic [SLOT_W-1:0] cnt_dec;
    logic              deq;
    logic              reply;
    logic              rsp_found;
    logic [BLK_W-1:0]  rsp_blk;
    logic [ITEM_W-1:0] rsp_item;

    hcgfe_ram #(
        .WIDTH ($bits(hcgfe_slot_t)),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rd)
    );

    hcgfe_ram #(
        .WIDTH ($bits(hcgfe_order_t)),
        .DEPTH (SLOTS)
    ) u_order_ram (
        .clk   (clk),
        .we    (order_we),
        .waddr (tail_reg),
        .wdata (order_wdata),
        .raddr (order_raddr),
        .rdata (order_rd)
    );

    assign hit    = slot_rd.used && (slot_rd.key == pkey_reg);
    assign demand = SUM_W'(count_reg) + SUM_W'(need_reg);
    assign cnt_dec = (count_reg != '0) ? count_reg - SLOT_W'(1) : count_reg;

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        req_next        = req_reg;
        need_next       = need_reg;
        first_next      = first_reg;
        pkey_next       = pkey_reg;
        pidx_next       = pidx_reg;
        hole_next       = hole_reg;
        scan_next       = scan_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        newest_blk_next = newest_blk_reg;
        newest_vld_next = newest_vld_reg;
        clr_addr_next   = clr_addr_reg;
        clr_reply_next  = clr_reply_reg;
        done_next       = 1'b0;
        result_next     = result_reg;

        slot_we          = 1'b0;
        slot_waddr       = pidx_reg;
        slot_wdata.used  = 1'b1;
        slot_wdata.key   = pkey_reg;
        slot_wdata.blk   = req_reg.block_value;
        slot_wdata.item  = req_reg.item_value;
        slot_raddr       = pidx_reg;
        order_we         = 1'b0;
        order_wdata.group_start = !(newest_vld_reg && (newest_blk_reg == req_reg.block_value));
        order_wdata.key  = pkey_reg;
        order_raddr      = head_reg;

        deq       = 1'b0;
        reply     = 1'b0;
        rsp_found = 1'b0;
        rsp_blk   = '0;
        rsp_item  = '0;

        unique case (state_reg)
            S_CLR:
            begin
                slot_we       = 1'b1;
                slot_waddr    = clr_addr_reg;
                slot_wdata    = '0;
                clr_addr_next = clr_addr_reg + SLOT_W'(1);
                if (clr_addr_reg == IDX_LAST)
                begin
                    clr_reply_next = 1'b0;
                    if (clr_reply_reg)
                    begin
                        reply = 1'b1;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = request;
                    unique case (request.cmd)
                        CMD_INSERT:
                        begin
                            need_next  = CNT_W'(1);
                            state_next = S_EV_CHK;
                        end
                        CMD_RESERVE:
                        begin
                            need_next  = request.room_count;
                            state_next = S_EV_CHK;
                        end
                        CMD_LOOKUP:
                        begin
                            mode_next  = MODE_LOOK;
                            pkey_next  = key_of(request);
                            pidx_next  = home_of(key_of(request));
                            slot_raddr = home_of(key_of(request));
                            state_next = S_PROBE;
                        end
                        CMD_CLEAR:
                        begin
                            head_next       = '0;
                            tail_next       = '0;
                            count_next      = '0;
                            newest_blk_next = '0;
                            newest_vld_next = 1'b0;
                            clr_addr_next   = '0;
                            clr_reply_next  = 1'b1;
                            state_next      = S_CLR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_EV_CHK:
            begin
                if ((count_reg != '0) && (demand > SUM_W'(limit)))
                begin
                    // queue head read is issued here by default
                    first_next = 1'b1;
                    state_next = S_EV_DAT;
                end
                else if (req_reg.cmd == CMD_INSERT)
                begin
                    mode_next  = MODE_INS;
                    pkey_next  = key_of(req_reg);
                    pidx_next  = home_of(key_of(req_reg));
                    slot_raddr = home_of(key_of(req_reg));
                    state_next = S_PROBE;
                end
                else
                begin
                    reply = 1'b1;
                end
            end
            S_EV_DAT:
            begin
                // first entry of a group always goes; later ones until next group start
                if (first_reg || !order_rd.group_start)
                begin
                    first_next = 1'b0;
                    mode_next  = MODE_EVICT;
                    pkey_next  = order_rd.key;
                    pidx_next  = home_of(order_rd.key);
                    slot_raddr = home_of(order_rd.key);
                    state_next = S_PROBE;
                end
                else
                begin
                    state_next = S_EV_CHK;
                end
            end
            S_PROBE:
            begin
                if (slot_rd.used && !hit)
                begin
                    // read of the following slot is in flight every cycle
                    pidx_next  = next_idx(pidx_reg);
                    slot_raddr = next_idx(pidx_reg);
                end
                else
                begin
                    unique case (mode_reg)
                        MODE_LOOK:
                        begin
                            reply     = 1'b1;
                            rsp_found = hit;
                            rsp_blk   = hit ? slot_rd.blk : '0;
                            rsp_item  = hit ? slot_rd.item : '0;
                        end
                        MODE_INS:
                        begin
                            slot_we = 1'b1;
                            if (!hit)
                            begin
                                order_we        = 1'b1;
                                tail_next       = next_idx(tail_reg);
                                newest_blk_next = req_reg.block_value;
                                newest_vld_next = 1'b1;
                                count_next      = count_reg + SLOT_W'(1);
                            end
                            reply     = 1'b1;
                            rsp_found = !hit;
                        end
                        MODE_EVICT:
                        begin
                            if (hit)
                            begin
                                hole_next  = pidx_reg;
                                scan_next  = next_idx(pidx_reg);
                                slot_raddr = next_idx(pidx_reg);
                                state_next = S_DEL;
                            end
                            else
                            begin
                                deq = 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_DEL:
            begin
                if (!slot_rd.used)
                begin
                    slot_we    = 1'b1;
                    slot_waddr = hole_reg;
                    slot_wdata = '0;
                    deq        = 1'b1;
                end
                else
                begin
                    if (!in_range(hole_reg, home_of(slot_rd.key), scan_reg))
                    begin
                        slot_we    = 1'b1;
                        slot_waddr = hole_reg;
                        slot_wdata = slot_rd;
                        hole_next  = scan_reg;
                    end
                    scan_next  = next_idx(scan_reg);
                    slot_raddr = next_idx(scan_reg);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (deq)
        begin
            head_next   = next_idx(head_reg);
            count_next  = cnt_dec;
            order_raddr = next_idx(head_reg);
            if (cnt_dec == '0)
            begin
                newest_vld_next = 1'b0;
                state_next      = S_EV_CHK;
            end
            else
            begin
                state_next = S_EV_DAT;
            end
        end

        if (reply)
        begin
            state_next               = S_IDLE;
            done_next                = 1'b1;
            result_next.found        = rsp_found;
            result_next.found_block  = rsp_blk;
            result_next.found_item   = rsp_item;
            result_next.entries_held = CNT_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            mode_reg       <= MODE_LOOK;
            first_reg      <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            newest_blk_reg <= '0;
            newest_vld_reg <= 1'b0;
            clr_addr_reg   <= '0;
            clr_reply_reg  <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            first_reg      <= first_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            newest_blk_reg <= newest_blk_next;
            newest_vld_reg <= newest_vld_next;
            clr_addr_reg   <= clr_addr_next;
            clr_reply_reg  <= clr_reply_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        need_reg   <= need_next;
        pkey_reg   <= pkey_next;
        pidx_reg   <= pidx_next;
        hole_reg   <= hole_next;
        scan_reg   <= scan_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    `HCGFE_ASSERT_NOW(a_done_idle, done_reg, state_reg == S_IDLE, "result strobe outside idle")
    `HCGFE_ASSERT_NOW(a_queue_len, 1'b1, SLOT_W'(tail_reg - head_reg) == count_reg, "queue length and entry count disagree")
    `HCGFE_ASSERT_NOW(a_shift_no_collide, (state_reg == S_DEL) && slot_we && slot_rd.used, slot_waddr != slot_raddr, "shift write hits scan read")
    `HCGFE_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted command did not raise busy")

endmodule

`default_nettype wire

// ===== rtl/hash_cache_with_group_fifo_eviction.sv =====
// ----------------------------------------------------------------------------
// hash_cache_with_group_fifo_eviction
// 256-bit key map to block/item with linear probing, backward-shift delete
// and whole-group FIFO eviction.
// ----------------------------------------------------------------------------
//  channel   | signals                         | transfer
//  ----------+---------------------------------+-------------------------------
//  command   | start, busy, request            | start high while busy low
//  result    | done, result                    | done high for one cycle
//  config    | cfg_valid, cfg_ready, cfg_data  | cfg_valid and cfg_ready high
//
// A lookup probes slot after slot until a hit or a free slot; insert and
// reserve first run the room check. done is high in the first cycle with
// busy low. Each evicted key takes a queue read, its probe and its
// backward-shift scan; each evicted group adds the group boundary read,
// unless the queue ran empty, and the next room check. The slot RAM has a
// single read port. After reset and after a clear command the slot RAM is
// swept, every slot cleared in turn, with busy high; config writes are
// taken at any time.
// Results cannot be stalled.
// SLOTS must be a power of two.
// ----------------------------------------------------------------------------
`default_nettype none

module hash_cache_with_group_fifo_eviction
    import hcgfe_pkg::*;
#(
    parameter int SLOTS = 16384
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire hcgfe_req_t       request,
    output logic                  done,
    output hcgfe_rsp_t            result,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CNT_W-1:0] cfg_data
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int LIM_W  = (SLOT_W > CNT_W) ? SLOT_W : CNT_W;

    logic [CNT_W-1:0]  max_entries_reg;
    logic [LIM_W-1:0]  lim_raw;
    logic [SLOT_W-1:0] limit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= MAX_ENTRIES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_entries_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    // zero means one; cap below the table size
    always_comb
    begin
        lim_raw = (max_entries_reg == '0) ? LIM_W'(1) : LIM_W'(max_entries_reg);
        if (lim_raw > LIM_W'(SLOTS - 1))
        begin
            lim_raw = LIM_W'(SLOTS - 1);
        end
        limit = SLOT_W'(lim_raw);
    end

    hcgfe_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .limit   (limit),
        .done    (done),
        .result  (result)
    );

endmodule

`default_nettype wire

// ===== sim/hash_cache_with_group_fifo_eviction_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_cache_with_group_fifo_eviction_tb
// Self-checking bench: a queue-fed command driver, a result monitor, and a
// shadow map with a probe table, backward-shift delete and group FIFO eviction.
// Phases run at several entry limits, random start gaps in all but the last.
// ----------------------------------------------------------------------------
`default_nettype none

module hash_cache_with_group_fifo_eviction_tb;
    import hcgfe_pkg::*;

    localparam int SLOTS     = 16384;
    localparam int IDLE_MAX  = 400000;
    localparam int PHASE_LEN = 175;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    hcgfe_req_t       request;
    logic             done;
    hcgfe_rsp_t       result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data;

    hash_cache_with_group_fifo_eviction #(.SLOTS(SLOTS)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------- shadow map ----------------
    bit           map_used [SLOTS];
    logic [255:0] map_key  [SLOTS];
    logic [63:0]  map_blk  [SLOTS];
    logic [31:0]  map_item [SLOTS];
    logic [255:0] fifo_key [SLOTS];
    bit           fifo_grp [SLOTS];
    int unsigned  fifo_head, fifo_tail, held;
    logic [63:0]  open_blk;
    bit           open_ok;
    int unsigned  max_reg = 10000;

    function automatic int unsigned nxt(int unsigned i);
        return (i + 1 >= SLOTS) ? 0 : i + 1;
    endfunction

    function automatic int unsigned cap_now();
        if (max_reg == 0) return 1;
        if (max_reg > SLOTS - 1) return SLOTS - 1;
        return max_reg;
    endfunction

    function automatic int probe(logic [255:0] k);
        int unsigned i;
        i = k[13:0];
        for (int n = 0; n < SLOTS; n++)
        begin
            if (!map_used[i]) return -1;
            if (map_key[i] == k) return i;
            i = nxt(i);
        end
        return -1;
    endfunction

    function automatic bit between(int unsigned lo, int unsigned h, int unsigned hi);
        if (lo <= hi) return h > lo && h <= hi;
        return h > lo || h <= hi;
    endfunction

    function automatic void unlink(int unsigned hole);
        int unsigned j;
        int unsigned h;
        j = nxt(hole);
        for (int n = 0; n < SLOTS && map_used[j]; n++)
        begin
            h = map_key[j][13:0];
            if (!between(hole, h, j))
            begin
                map_key[hole]  = map_key[j];
                map_blk[hole]  = map_blk[j];
                map_item[hole] = map_item[j];
                hole = j;
            end
            j = nxt(j);
        end
        map_used[hole] = 1'b0;
    endfunction

    function automatic void drop_oldest();
        int s;
        s = probe(fifo_key[fifo_head]);
        if (s >= 0) unlink(s);
        fifo_head = nxt(fifo_head);
        if (held > 0) held--;
        if (held == 0) open_ok = 1'b0;
    endfunction

    function automatic void make_space(int unsigned need);
        int unsigned lim;
        lim = cap_now();
        while (held > 0 && held + need > lim)
        begin
            drop_oldest();
            while (held > 0 && !fifo_grp[fifo_head]) drop_oldest();
        end
    endfunction

    function automatic void wipe_map();
        for (int i = 0; i < SLOTS; i++) map_used[i] = 1'b0;
        fifo_head = 0;
        fifo_tail = 0;
        held      = 0;
        open_blk  = '0;
        open_ok   = 1'b0;
    endfunction

    function automatic hcgfe_rsp_t map_cmd(hcgfe_req_t r);
        hcgfe_rsp_t   o;
        logic [255:0] k;
        int           s;
        int unsigned  i;
        o = '0;
        k = {r.key_word3, r.key_word2, r.key_word1, r.key_word0};
        case (r.cmd)
            CMD_INSERT:
            begin
                if (held >= cap_now()) make_space(1);
                i = k[13:0];
                while (map_used[i] && map_key[i] != k) i = nxt(i);
                map_blk[i]  = r.block_value;
                map_item[i] = r.item_value;
                if (!map_used[i])
                begin
                    map_used[i]         = 1'b1;
                    map_key[i]          = k;
                    fifo_key[fifo_tail] = k;
                    fifo_grp[fifo_tail] = !(open_ok && open_blk == r.block_value);
                    fifo_tail           = nxt(fifo_tail);
                    open_blk            = r.block_value;
                    open_ok             = 1'b1;
                    held++;
                    o.found = 1'b1;
                end
            end
            CMD_LOOKUP:
            begin
                s = probe(k);
                if (s >= 0)
                begin
                    o.found       = 1'b1;
                    o.found_block = map_blk[s];
                    o.found_item  = map_item[s];
                end
            end
            CMD_RESERVE: make_space(r.room_count);
            default:     wipe_map();
        endcase
        o.entries_held = held[CNT_W-1:0];
        return o;
    endfunction

    // ---------------- driver ----------------
    hcgfe_req_t cmd_pending[$];
    hcgfe_rsp_t rsp_due[$];
    hcgfe_rsp_t exp_rsp;
    int  gap_left;
    bit  quiet;
    bit  took;
    bit  cfg_took;
    int  n_cmds, n_hits, n_clears, errors;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            request  <= '0;
            gap_left = 0;
            took     = 1'b0;
        end
        else
        begin
            took = start && !busy;
            if (took)
            begin
                exp_rsp = map_cmd(request);
                rsp_due.push_back(exp_rsp);
                if (request.cmd == CMD_CLEAR) n_clears++;
                if (request.cmd == CMD_LOOKUP && exp_rsp.found) n_hits++;
                void'(cmd_pending.pop_front());
                n_cmds++;
            end
            if (start && !took)
                ; // transaction still waiting, keep it up
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (cmd_pending.size() > 0)
            begin
                start   <= 1'b1;
                request <= cmd_pending[0];
                if (!quiet && $urandom_range(0, 6) == 0) gap_left = $urandom_range(1, 13);
            end
            else
                start <= 1'b0;
        end
    end

    // ---------------- monitor ----------------
    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        hcgfe_rsp_t w;
        if (rst_n && done)
        begin
            if (rsp_due.size() == 0)
                report("unexpected result", result.entries_held, 0);
            else
            begin
                w = rsp_due.pop_front();
                if (result.found != w.found) report("found", result.found, w.found);
                if (result.found_block != w.found_block)
                    report("found_block", result.found_block, w.found_block);
                if (result.found_item != w.found_item)
                    report("found_item", result.found_item, w.found_item);
                if (result.entries_held != w.entries_held)
                    report("entries_held", result.entries_held, w.entries_held);
            end
        end
    end

    // ---------------- watchdog ----------------
    int idle_cycles;
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    logic [255:0] key_pool[64];

    function automatic logic [255:0] fresh_key(int unsigned base);
        logic [255:0] k;
        k = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        k[13:0] = (base + $urandom_range(0, 40)) % SLOTS;
        return k;
    endfunction

    function automatic hcgfe_req_t pack_cmd(logic [1:0] c, logic [255:0] k,
                                            logic [63:0] b, logic [31:0] it,
                                            logic [13:0] rc);
        hcgfe_req_t r;
        r.cmd         = c;
        r.key_word0   = k[63:0];
        r.key_word1   = k[127:64];
        r.key_word2   = k[191:128];
        r.key_word3   = k[255:192];
        r.block_value = b;
        r.item_value  = it;
        r.room_count  = rc;
        return r;
    endfunction

    task automatic settle();
        while (cmd_pending.size() > 0 || start || rsp_due.size() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_max(logic [CNT_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        max_reg = v;
    endtask

    int unsigned limits[8] = '{1, 0, 16383, 5, 40, 200, 3, 10000};

    initial
    begin
        int unsigned  base;
        int unsigned  pick;
        logic [63:0]  tags[4];
        logic [255:0] k;
        logic [1:0]   c;
        logic [13:0]  rc;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        quiet     = 1'b0;
        errors    = 0;
        wipe_map();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset limit, extremes of the fields, update, miss, clear
        k = '1;
        cmd_pending.push_back(pack_cmd(CMD_LOOKUP, k, 0, 0, 0));
        cmd_pending.push_back(pack_cmd(CMD_INSERT, k, '1, '1, '1));
        cmd_pending.push_back(pack_cmd(CMD_LOOKUP, k, 0, 0, 0));
        cmd_pending.push_back(pack_cmd(CMD_INSERT, '0, '0, '0, '0));
        cmd_pending.push_back(pack_cmd(CMD_INSERT, k, 64'h5, 32'h7, 0));
        cmd_pending.push_back(pack_cmd(CMD_LOOKUP, k, '1, '1, '1));
        cmd_pending.push_back(pack_cmd(CMD_LOOKUP, '0, 0, 0, 0));
        // keys wrapping around the table end, then delete from the middle
        for (int i = 0; i < 4; i++)
            cmd_pending.push_back(pack_cmd(CMD_INSERT, {192'h0, 50'(i), 14'h3fff},
                                           64'(i), 32'(i), 0));
        cmd_pending.push_back(pack_cmd(CMD_RESERVE, '0, 0, 0, 14'd0));
        cmd_pending.push_back(pack_cmd(CMD_RESERVE, '0, 0, 0, 14'd9997));
        cmd_pending.push_back(pack_cmd(CMD_LOOKUP, {192'h0, 50'd3, 14'h3fff}, 0, 0, 0));
        cmd_pending.push_back(pack_cmd(CMD_RESERVE, '0, 0, 0, 14'h3fff));
        cmd_pending.push_back(pack_cmd(CMD_INSERT, k, 1, 1, 0));
        cmd_pending.push_back(pack_cmd(CMD_CLEAR, k, 1, 1, 0));
        cmd_pending.push_back(pack_cmd(CMD_LOOKUP, k, 0, 0, 0));
        settle();

        for (int p = 0; p < 8; p++)
        begin
            write_max(CNT_W'(limits[p]));
            if (p == 7) quiet = 1'b1;
            base = $urandom_range(0, SLOTS - 1);
            foreach (key_pool[i]) key_pool[i] = fresh_key(base);
            foreach (tags[i]) tags[i] = {$urandom, $urandom};
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                pick = $urandom_range(0, 199);
                if (pick < 100) c = CMD_INSERT;
                else if (pick < 160) c = CMD_LOOKUP;
                else if (pick < 198) c = CMD_RESERVE;
                else c = CMD_CLEAR;
                k = ($urandom_range(0, 9) == 0) ? fresh_key($urandom)
                                                 : key_pool[$urandom_range(0, 63)];
                rc = ($urandom_range(0, 7) == 0) ? 14'($urandom) : 14'($urandom_range(0, 6));
                cmd_pending.push_back(pack_cmd(c, k,
                    ($urandom_range(0, 5) == 0) ? {$urandom, $urandom} : tags[$urandom_range(0, 3)],
                    $urandom, rc));
            end
            settle(); // sender holds off until every result is back
        end

        repeat (50) @(posedge clk);
        $display("Ran %0d commands (%0d clears, %0d lookup hits) over 8 entry limits.",
                 n_cmds, n_clears, n_hits);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
